// ===== design/sorted_list_insert_remove_defines.svh =====
// Assertion macros shared by the sorted list checker.
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// Implication checked in the same cycle; uses clk and rst_n of the enclosing scope.
`define SLIR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define SLIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/slir_pkg.sv =====
// Package with sizes, codes and types of the sorted list.
package slir_pkg;

    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // write enables broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

    // result fields, status in the lowest bits
    typedef struct packed {
        logic               full_flag;
        logic               empty_flag;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== design/sorted_list_insert_remove.sv =====
// Top level of the sorted list with insert and remove requests.
//
// Sorted list of up to DEPTH signed 32-bit values kept in ascending order in a
// row of cells. A request carries the opcode in s_tuser (insert or remove) and
// the value in s_tdata. Insert places the value after every entry less than or
// equal to it; remove deletes one entry equal to it. Every request gives one
// result: status (ok, full on insert, empty on remove, not found), the count
// after the request and empty and full flags. All cells compare against the
// value in parallel and shift their neighbor's entry in the same clock, so a
// new request is taken every cycle while the result register is free or being
// drained. The result is registered and offered in the cycle after acceptance.
// Entries hold no reset; only the first count cells are ever read.
module sorted_list_insert_remove (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [slir_pkg::VALUE_W-1:0]    s_tdata,    // [31:0] value
    input  logic [0:0]                      s_tuser,    // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [slir_pkg::M_TDATA_W-1:0]  m_tdata     // [1:0] status, [6:2] count,
                                                        // [7] empty_flag, [8] full_flag
);
    import slir_pkg::*;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    result_t                   result_reg;
    result_t                   result_next;
    status_t                   status;

    logic                      accept;
    op_t                       opcode;
    logic signed [VALUE_W-1:0] value;
    logic                      is_full;
    logic                      list_empty;
    logic                      found;
    cell_ctrl_t                ctrl;

    // neighbor links of the chain
    logic signed [VALUE_W-1:0] entry_w [DEPTH];
    logic [DEPTH-1:0]          le_w;
    logic [DEPTH-1:0]          lt_w;
    logic [DEPTH-1:0]          hit_w;
    logic [DEPTH-1:0]          occupied;

    // output register parts the sides: take a request whenever it is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign opcode   = op_t'(s_tuser[0]);
    assign value    = signed'(s_tdata);

    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);
    // entries are sorted, so at most one cell sits on the lower boundary of the value
    assign found    = |hit_w;

    assign ctrl.ins_en = accept && (opcode == OP_INSERT) && !is_full;
    assign ctrl.rem_en = accept && (opcode == OP_REMOVE) && found;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] prev_entry;
        logic signed [VALUE_W-1:0] next_entry;
        logic                      prev_le;
        logic                      prev_lt;

        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign prev_entry = value;
            assign prev_le    = 1'b1;
            assign prev_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign prev_entry = entry_w[i-1];
            assign prev_le    = le_w[i-1];
            assign prev_lt    = lt_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_entry = entry_w[i];
        end
        else
        begin : g_inner
            assign next_entry = entry_w[i+1];
        end

        slir_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (value),
            .occupied   (occupied[i]),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .prev_le    (prev_le),
            .prev_lt    (prev_lt),
            .entry      (entry_w[i]),
            .le         (le_w[i]),
            .lt         (lt_w[i]),
            .hit        (hit_w[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        status     = STATUS_OK;
        case (opcode)
            OP_INSERT:
            begin
                if (is_full)
                    status = STATUS_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            OP_REMOVE:
            begin
                if (list_empty)
                    status = STATUS_EMPTY;
                else if (!found)
                    status = STATUS_NOT_FOUND;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
                status = STATUS_OK;
            end
        endcase
        if (!accept)
            count_next = count_reg;
    end

    always_comb
    begin
        result_next.status     = status;
        result_next.count      = COUNT_W'(count_next);
        result_next.empty_flag = (count_next == '0);
        result_next.full_flag  = (count_next == CNT_W'(DEPTH));
        m_valid_next           = accept || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg);

endmodule

// ===== design/slir_cell.sv =====
// One storage cell of the sorted list chain.
module slir_cell (
    input  logic                              clk,
    input  slir_pkg::cell_ctrl_t              ctrl,
    input  logic signed [slir_pkg::VALUE_W-1:0] value,
    input  logic                              occupied,
    input  logic signed [slir_pkg::VALUE_W-1:0] prev_entry,
    input  logic signed [slir_pkg::VALUE_W-1:0] next_entry,
    input  logic                              prev_le,
    input  logic                              prev_lt,
    output logic signed [slir_pkg::VALUE_W-1:0] entry,
    output logic                              le,
    output logic                              lt,
    output logic                              hit
);
    import slir_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    assign entry = entry_reg;
    assign le    = occupied && (entry_reg <= value);
    assign lt    = occupied && (entry_reg < value);
    // first cell not below the value, and equal to it
    assign hit   = prev_lt && !lt && occupied && (entry_reg == value);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (!le)
                entry_next = prev_le ? value : prev_entry;
        end
        else if (ctrl.rem_en)
        begin
            if (!lt)
                entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/slir_checker.sv =====
// Port-level assertions for the sorted list, bound to the top level.
`include "sorted_list_insert_remove_defines.svh"

module slir_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [slir_pkg::VALUE_W-1:0]    s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [slir_pkg::M_TDATA_W-1:0]  m_tdata
);
    import slir_pkg::*;

    logic    s_fire;
    logic    s_remove;
    logic    s_insert;
    logic    m_stall;
    logic    m_insert_code;
    status_t m_status;

    assign s_fire        = s_tvalid && s_tready;
    assign s_remove      = s_fire && (s_tuser[0] == OP_REMOVE);
    assign s_insert      = s_fire && (s_tuser[0] == OP_INSERT);
    assign m_stall       = m_tvalid && !m_tready;
    assign m_status      = status_t'(m_tdata[1:0]);
    assign m_insert_code = (m_status == STATUS_OK) || (m_status == STATUS_FULL);

    // a stalled result stays offered and unchanged
    `SLIR_ASSERT_NEXT(a_hold_valid, m_stall, m_tvalid, "result dropped while stalled")
    `SLIR_ASSERT_NEXT(a_hold_data, m_stall, $stable(m_tdata), "result changed while stalled")
    // every accepted request shows a result next cycle
    `SLIR_ASSERT_NEXT(a_result_follows, s_fire, m_tvalid, "no result after accepted request")
    // remove never reports full; insert reports only ok or full
    `SLIR_ASSERT_NEXT(a_remove_status, s_remove, m_status != STATUS_FULL, "remove returned full")
    `SLIR_ASSERT_NEXT(a_insert_status, s_insert, m_insert_code, "insert returned remove status")

endmodule

bind sorted_list_insert_remove slir_checker u_slir_checker (.*);

// ===== tb/sv/tb_sorted_list_insert_remove.sv =====
// Self-checking testbench for the sorted list with insert and remove requests.
module tb_sorted_list_insert_remove;

    import slir_pkg::*;

    // No handshake on either side for this many cycles means the DUT hung.
    // A correct run never goes beyond one sender gap plus one result stall
    // plus the pass through the result register.
    localparam int STALL_LIMIT = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata;     // [31:0] value
    logic [0:0]             s_tuser;     // [0] opcode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;     // [1:0] status, [6:2] count,
                                         // [7] empty_flag, [8] full_flag

    // Mirror of the list contents, kept ascending, updated at each accepted request.
    int        stored_values[$];
    // Results owed by the DUT, oldest first.
    result_t   pending_results[$];

    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    // Set during burst phases: neither side inserts idle cycles.
    bit        no_idle        = 1'b0;

    // Values that collide often, so removes hit and duplicates pile up.
    int        value_pool[8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 7, -7, 100};

    sorted_list_insert_remove DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the mirror and return the result it must produce.
    // Insert goes after every entry <= value, i.e. before the first larger one.
    function automatic result_t apply_to_sorted_list(op_t op, int value);
        result_t res;
        int      pos;
        res.status = STATUS_OK;
        if (op == OP_INSERT)
        begin
            if (stored_values.size() >= DEPTH)
                res.status = STATUS_FULL;
            else
            begin
                pos = 0;
                while (pos < stored_values.size() && stored_values[pos] <= value)
                    pos++;
                stored_values.insert(pos, value);
            end
        end
        else if (stored_values.size() == 0)
            res.status = STATUS_EMPTY;
        else
        begin
            pos = 0;
            while (pos < stored_values.size() && stored_values[pos] != value)
                pos++;
            if (pos >= stored_values.size())
                res.status = STATUS_NOT_FOUND;
            else
                stored_values.delete(pos);
        end
        res.count      = COUNT_W'(stored_values.size());
        res.empty_flag = (stored_values.size() == 0);
        res.full_flag  = (stored_values.size() >= DEPTH);
        return res;
    endfunction

    // Called and returns at a falling edge. tvalid stays high across back-to-back
    // requests, so it is only ever written once per edge.
    task automatic send_request(op_t op, int value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = value;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(apply_to_sorted_list(op, value));
        @(negedge clk);
    endtask

    // Hold off new requests until the DUT has returned everything owed.
    task automatic wait_for_all_results();
        s_tvalid = 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    // Empty list, extreme values, duplicates and misses.
    task automatic test_corner_values();
        send_request(OP_REMOVE, 0);                   // remove on empty list
        send_request(OP_INSERT, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_INSERT, 0);
        send_request(OP_INSERT, -1);
        send_request(OP_INSERT, 0);                   // duplicate goes after its twin
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_REMOVE, 5);                   // absent, inside the range
        send_request(OP_INSERT, 32'sh5555_5555);
        send_request(OP_REMOVE, 32'sh2AAA_AAAA);      // absent
        send_request(OP_REMOVE, 0);
        send_request(OP_REMOVE, 32'sh8000_0000);
        send_request(OP_REMOVE, 32'sh7FFF_FFFF);
        send_request(OP_REMOVE, 32'sh7FFF_FFFF);      // absent, above every entry
        send_request(OP_REMOVE, 32'sh8000_0000);
        send_request(OP_REMOVE, -1);
        send_request(OP_REMOVE, 0);
        send_request(OP_REMOVE, 32'sh5555_5555);      // list empty again
        send_request(OP_REMOVE, 32'sh8000_0000);      // remove on empty list
    endtask

    // Fill to DEPTH, push against the full list, then drain in random order.
    task automatic test_full_list();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_request(OP_INSERT, (i % 3 == 0) ? value_pool[$urandom_range(0, 7)]
                                                 : int'($urandom));
        send_request(OP_INSERT, 0);                   // full
        send_request(OP_INSERT, 32'sh7FFF_FFFF);      // full
        send_request(OP_REMOVE, 12345);               // most likely absent
        while (stored_values.size() > 0)
            send_request(OP_REMOVE, stored_values[$urandom_range(0, stored_values.size() - 1)]);
        send_request(OP_REMOVE, 1);                   // empty
    endtask

    // Mostly well-formed traffic: removes usually name a stored value.
    // insert_pct steers the fill level toward full or toward empty.
    task automatic test_random_traffic(int n_items, bit gapless, int insert_pct);
        op_t op;
        int  value;
        int  pick;
        no_idle = gapless;
        repeat (n_items)
        begin
            op   = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
            pick = $urandom_range(0, 9);
            if (op == OP_REMOVE && stored_values.size() > 0 && pick < 7)
                value = stored_values[$urandom_range(0, stored_values.size() - 1)];
            else if (pick < 4)
                value = value_pool[$urandom_range(0, 7)];
            else
                value = $urandom;
            send_request(op, value);
        end
        no_idle = 1'b0;
    endtask

    // Sender goes quiet mid-run until the result side has caught up.
    task automatic test_drain_pause();
        test_random_traffic(20, 1'b1, 55);
        wait_for_all_results();
        test_random_traffic(20, 1'b0, 55);
    endtask

    // Result side: random stall before each result, none during bursts.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    task automatic check_field(string name, int expected_v, int actual_v);
        if (expected_v != actual_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_v, actual_v);
            mismatch_count++;
        end
    endtask

    // Compare each returned result with the oldest one owed.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("count", want.count, got.count);
                check_field("empty_flag", want.empty_flag, got.empty_flag);
                check_field("full_flag", want.full_flag, got.full_flag);
                check_field("tdata padding", 0, int'(m_tdata >> RESULT_W));
            end
        end
    end

    // Progress monitor: any handshake on either side resets the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_INSERT;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_values();
        test_full_list();
        test_random_traffic(450, 1'b0, 60);
        test_random_traffic(250, 1'b1, 50);
        test_drain_pause();
        test_random_traffic(450, 1'b0, 40);
        test_random_traffic(130, 1'b1, 55);

        wait_for_all_results();
        // spare edges after the last result catch any stray result
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/slir_pkg.sv
design/slir_cell.sv
design/sorted_list_insert_remove.sv
design/slir_checker.sv
tb/sv/tb_sorted_list_insert_remove.sv
